>>> hw/rtl/pnf_pkg.sv
// pnf_pkg: shared widths, constants, permutation rom and helper functions
// for the fractal perlin noise unit; no dependencies
package pnf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int FREQ_W    = 31;
  localparam int LAC_W     = 18;
  localparam int AMP_W     = 16;
  localparam int OCT_W     = 4;
  localparam int CELL_W    = 8;
  localparam int FRAC_W    = 16;
  localparam int FADE_W    = 17;
  localparam int POLY_W    = 20;
  localparam int GRAD_W    = 19;
  localparam int NZ_W      = 20;
  localparam int TERM_W    = 20;
  localparam int OUT_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;
  localparam int LANE_LAT  = 7;

  localparam logic [FREQ_W-1:0] FREQ_ONE  = FREQ_W'(1 << FRAC_BITS);
  localparam logic [POLY_W-1:0] FADE_C15  = POLY_W'(15 * (1 << FRAC_BITS));
  localparam logic [POLY_W-1:0] FADE_C10  = POLY_W'(10 * (1 << FRAC_BITS));
  localparam int                OUT_SHIFT = FRAC_BITS - 14;
  localparam int                OUT_MAX   = 131071;
  localparam int                OUT_MIN   = -131072;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN            = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_AMPLITUDE = 2'd3;

  localparam logic [OCT_W-1:0] RST_OCTAVE_COUNT    = 4'd3;
  localparam logic [LAC_W-1:0] RST_LACUNARITY      = 18'd137626;
  localparam logic [AMP_W-1:0] RST_GAIN            = 16'd31457;
  localparam logic [AMP_W-1:0] RST_START_AMPLITUDE = 16'd32768;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180};

  // diagonal gradient dot product picked by hash bits 1..0
  function automatic logic signed [GRAD_W-1:0] grad(input logic [CELL_W-1:0] h,
                                                    input logic signed [GRAD_W-1:0] px,
                                                    input logic signed [GRAD_W-1:0] py);
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = h[1] ? py : px;
    v = h[1] ? px : py;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // a + floor(t * (b - a) / 2^FRAC_BITS)
  function automatic logic signed [NZ_W-1:0] lerp(input logic signed [NZ_W-1:0] a,
                                                  input logic signed [NZ_W-1:0] b,
                                                  input logic [FADE_W-1:0] t);
    logic signed [NZ_W:0]            diff;
    logic signed [FADE_W+NZ_W+1:0]   prod;
    logic signed [FADE_W+NZ_W+1:0]   sh;
    diff = $signed({b[NZ_W-1], b}) - $signed({a[NZ_W-1], a});
    prod = $signed({1'b0, t}) * diff;
    sh   = prod >>> FRAC_BITS;
    return a + $signed(sh[NZ_W-1:0]);
  endfunction

endpackage

>>> hw/rtl/pnf_coef_seq.sv
// pnf_coef_seq: steps the per-octave frequency and amplitude tables after
// reset and after every configuration write; uses pnf_pkg
module pnf_coef_seq import pnf_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               restart,
  input  logic [LAC_W-1:0]                   lacunarity,
  input  logic [AMP_W-1:0]                   gain,
  input  logic [AMP_W-1:0]                   start_amplitude,
  output logic [MAX_OCTAVES-1:0][FREQ_W-1:0] freq_tab,
  output logic [MAX_OCTAVES-1:0][AMP_W-1:0]  amp_tab,
  output logic                               busy
);

  localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  logic                               restart_r;
  logic                               busy_r;
  logic [IDX_W-1:0]                   idx_r;
  logic [FREQ_W-1:0]                  freq_acc_r;
  logic [AMP_W-1:0]                   amp_acc_r;
  logic [MAX_OCTAVES-1:0][FREQ_W-1:0] freq_tab_r;
  logic [MAX_OCTAVES-1:0][AMP_W-1:0]  amp_tab_r;
  logic [FREQ_W+LAC_W-1:0]            freq_prod;
  logic [2*AMP_W-1:0]                 amp_prod;
  logic [FREQ_W-1:0]                  freq_nxt;
  logic [AMP_W-1:0]                   amp_nxt;

  always_comb begin
    freq_prod = FREQ_W'(freq_acc_r) * (FREQ_W+LAC_W)'(lacunarity);
    amp_prod  = (2*AMP_W)'(amp_acc_r) * (2*AMP_W)'(gain);
    // saturate at 2^31-1
    if (|freq_prod[FREQ_W+LAC_W-1:FREQ_W+FRAC_BITS]) begin
      freq_nxt = '1;
    end else begin
      freq_nxt = freq_prod[FREQ_W+FRAC_BITS-1:FRAC_BITS];
    end
    amp_nxt = amp_prod[2*AMP_W-1:AMP_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
      busy_r    <= 1'b0;
      idx_r     <= '0;
    end else if (restart) begin
      restart_r <= 1'b1;
    end else if (restart_r) begin
      restart_r <= 1'b0;
      busy_r    <= 1'b1;
      idx_r     <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == IDX_W'(MAX_OCTAVES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (restart_r) begin
      freq_acc_r <= FREQ_ONE;
      amp_acc_r  <= start_amplitude;
    end else if (busy_r) begin
      freq_tab_r[idx_r] <= freq_acc_r;
      amp_tab_r[idx_r]  <= amp_acc_r;
      freq_acc_r        <= freq_nxt;
      amp_acc_r         <= amp_nxt;
    end
  end

  assign freq_tab = freq_tab_r;
  assign amp_tab  = amp_tab_r;
  assign busy     = busy_r | restart_r;

endmodule

>>> hw/rtl/pnf_octave_lane.sv
// pnf_octave_lane: seven-stage pipeline for one octave: scale, hash, fade,
// gradients, lerps and amplitude weight; uses pnf_pkg
module pnf_octave_lane import pnf_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic [FREQ_W-1:0]         freq,
  input  logic [AMP_W-1:0]          amp,
  input  logic                      lane_on,
  output logic signed [TERM_W-1:0]  term
);

  // stage 1: scaled coordinate split into cell and fraction
  logic [CELL_W-1:0]          s1_cell_r [2];
  logic [FRAC_W-1:0]          s1_frac_r [2];
  // stage 2
  logic [CELL_W-1:0]          s2_pa_r, s2_pb_r, s2_yi_r;
  logic [FRAC_W-1:0]          s2_frac_r [2];
  logic [FRAC_W-1:0]          s2_t2_r   [2];
  logic [POLY_W-1:0]          s2_ia_r   [2];
  // stage 3
  logic [CELL_W-1:0]          s3_haa_r, s3_hab_r, s3_hba_r, s3_hbb_r;
  logic [FRAC_W-1:0]          s3_frac_r [2];
  logic [FRAC_W-1:0]          s3_t3_r   [2];
  logic [POLY_W-1:0]          s3_in_r   [2];
  // stage 4
  logic [FADE_W-1:0]          s4_fade_r [2];
  logic signed [GRAD_W-1:0]   s4_gaa_r, s4_gab_r, s4_gba_r, s4_gbb_r;
  // stage 5
  logic [FADE_W-1:0]          s5_v_r;
  logic signed [NZ_W-1:0]     s5_lo_r, s5_hi_r;
  // stage 6
  logic signed [NZ_W-1:0]     s6_nz_r;
  // stage 7
  logic signed [TERM_W-1:0]   s7_term_r;

  logic signed [2*COORD_W-1:0] scaled [2];
  logic [2*FRAC_W-1:0]         t2_prod [2];
  logic [POLY_W-1:0]           six_t [2];
  logic [FRAC_W+POLY_W-1:0]    ia_prod [2];
  logic [2*FRAC_W-1:0]         t3_prod [2];
  logic [FRAC_W+POLY_W-1:0]    fade_prod [2];
  logic signed [GRAD_W-1:0]    px0, px1, py0, py1;
  logic signed [AMP_W+NZ_W:0]  amp_prod;
  logic signed [AMP_W+NZ_W:0]  amp_sh;

  always_comb begin
    scaled[0] = $signed(x_coord) * $signed({1'b0, freq});
    scaled[1] = $signed(y_coord) * $signed({1'b0, freq});
    for (int d = 0; d < 2; d++) begin
      t2_prod[d]   = (2*FRAC_W)'(s1_frac_r[d]) * (2*FRAC_W)'(s1_frac_r[d]);
      six_t[d]     = POLY_W'({s1_frac_r[d], 2'b00}) + POLY_W'({s1_frac_r[d], 1'b0});
      ia_prod[d]   = (FRAC_W+POLY_W)'(s1_frac_r[d]) * (FRAC_W+POLY_W)'(FADE_C15 - six_t[d]);
      t3_prod[d]   = (2*FRAC_W)'(s2_t2_r[d]) * (2*FRAC_W)'(s2_frac_r[d]);
      fade_prod[d] = (FRAC_W+POLY_W)'(s3_t3_r[d]) * (FRAC_W+POLY_W)'(s3_in_r[d]);
    end
    // corner offsets: fraction and fraction minus one
    px0 = $signed(GRAD_W'({1'b0, s3_frac_r[0]}));
    py0 = $signed(GRAD_W'({1'b0, s3_frac_r[1]}));
    px1 = px0 - $signed(GRAD_W'(1 << FRAC_BITS));
    py1 = py0 - $signed(GRAD_W'(1 << FRAC_BITS));
    amp_prod = $signed({1'b0, amp}) * s6_nz_r;
    amp_sh   = amp_prod >>> AMP_W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cell_r[0] <= scaled[0][2*FRAC_BITS+CELL_W-1:2*FRAC_BITS];
      s1_cell_r[1] <= scaled[1][2*FRAC_BITS+CELL_W-1:2*FRAC_BITS];
      s1_frac_r[0] <= scaled[0][2*FRAC_BITS-1:2*FRAC_BITS-FRAC_W];
      s1_frac_r[1] <= scaled[1][2*FRAC_BITS-1:2*FRAC_BITS-FRAC_W];

      s2_pa_r <= PERM_ROM[s1_cell_r[0]];
      s2_pb_r <= PERM_ROM[s1_cell_r[0] + 1'b1];
      s2_yi_r <= s1_cell_r[1];
      for (int d = 0; d < 2; d++) begin
        s2_frac_r[d] <= s1_frac_r[d];
        s2_t2_r[d]   <= t2_prod[d][2*FRAC_W-1:FRAC_BITS];
        s2_ia_r[d]   <= ia_prod[d][FRAC_W+POLY_W-1:FRAC_BITS];
      end

      s3_haa_r <= PERM_ROM[s2_pa_r + s2_yi_r];
      s3_hab_r <= PERM_ROM[s2_pa_r + s2_yi_r + 1'b1];
      s3_hba_r <= PERM_ROM[s2_pb_r + s2_yi_r];
      s3_hbb_r <= PERM_ROM[s2_pb_r + s2_yi_r + 1'b1];
      for (int d = 0; d < 2; d++) begin
        s3_frac_r[d] <= s2_frac_r[d];
        s3_t3_r[d]   <= t3_prod[d][2*FRAC_W-1:FRAC_BITS];
        s3_in_r[d]   <= FADE_C10 - s2_ia_r[d];
      end

      for (int d = 0; d < 2; d++) begin
        s4_fade_r[d] <= fade_prod[d][FRAC_BITS+FADE_W-1:FRAC_BITS];
      end
      s4_gaa_r <= grad(s3_haa_r, px0, py0);
      s4_gba_r <= grad(s3_hba_r, px1, py0);
      s4_gab_r <= grad(s3_hab_r, px0, py1);
      s4_gbb_r <= grad(s3_hbb_r, px1, py1);

      s5_v_r  <= s4_fade_r[1];
      s5_lo_r <= lerp(NZ_W'(s4_gaa_r), NZ_W'(s4_gba_r), s4_fade_r[0]);
      s5_hi_r <= lerp(NZ_W'(s4_gab_r), NZ_W'(s4_gbb_r), s4_fade_r[0]);

      s6_nz_r <= lerp(s5_lo_r, s5_hi_r, s5_v_r);

      s7_term_r <= lane_on ? $signed(amp_sh[TERM_W-1:0]) : '0;
    end
  end

  assign term = s7_term_r;

endmodule

>>> hw/rtl/pnf_sum.sv
// pnf_sum: registered sum of the weighted octave terms; uses pnf_pkg
module pnf_sum import pnf_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int SUM_W       = 24
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [MAX_OCTAVES-1:0][TERM_W-1:0] terms,
  output logic signed [SUM_W-1:0]            sum
);

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] sum_r;

  always_comb begin
    acc = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      acc = acc + SUM_W'($signed(terms[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= acc;
    end
  end

  assign sum = sum_r;

endmodule

>>> hw/rtl/perlin_noise_fbm_2d_unit.sv
// perlin_noise_fbm_2d_unit: top level of the fractal 2d perlin noise unit
// depends on pnf_pkg, pnf_coef_seq, pnf_octave_lane and pnf_sum
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_stall, in_x_coord, in_y_coord | in
//   result  | out_valid, out_stall, out_noise_sum        | out
//   config  | cfg_we, cfg_index, cfg_wdata               | in
//
// one coordinate transfer per cycle while in_stall is low; each result passes
// through the 7 lane stages, the term sum and the saturating output register
// all octaves run as parallel lanes, so throughput is set by the lane pipeline
// after reset and after each config write the frequency/amplitude sequencer
// rebuilds its tables, and in_stall is held high while it runs
// out_stall on a valid result freezes all stages; nothing is lost or repeated
module perlin_noise_fbm_2d_unit import pnf_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_W-1:0]   in_x_coord,
  input  logic signed [COORD_W-1:0]   in_y_coord,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     out_noise_sum,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_wdata
);

  // sum grows by the log of the lane count plus one bit
  localparam int SUM_W = TERM_W + $clog2(MAX_OCTAVES) + 1;
  localparam int LIM_W = $clog2(MAX_OCTAVES + 1) + 1;

  // configuration registers
  logic [OCT_W-1:0] octave_count_r;
  logic [LAC_W-1:0] lacunarity_r;
  logic [AMP_W-1:0] gain_r;
  logic [AMP_W-1:0] start_amplitude_r;

  logic [MAX_OCTAVES-1:0][FREQ_W-1:0] freq_tab;
  logic [MAX_OCTAVES-1:0][AMP_W-1:0]  amp_tab;
  logic [MAX_OCTAVES-1:0][TERM_W-1:0] terms;
  logic [MAX_OCTAVES-1:0]             lane_on;
  logic                               seq_busy;

  logic [LANE_LAT-1:0]                vld_r;
  logic                               sum_vld_r;
  logic                               out_valid_r;
  logic signed [OUT_W-1:0]            out_noise_sum_r;
  logic signed [OUT_W-1:0]            out_noise_sum_nxt;

  logic                               adv;
  logic                               in_xfer;
  logic [LIM_W-1:0]                   oct_lim;
  logic signed [SUM_W-1:0]            sum;
  logic signed [SUM_W-1:0]            q;

  // whole pipe moves unless a finished result is held back
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv || seq_busy;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r    <= RST_OCTAVE_COUNT;
      lacunarity_r      <= RST_LACUNARITY;
      gain_r            <= RST_GAIN;
      start_amplitude_r <= RST_START_AMPLITUDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCTAVE_COUNT:    octave_count_r    <= cfg_wdata[OCT_W-1:0];
        CFG_LACUNARITY:      lacunarity_r      <= cfg_wdata[LAC_W-1:0];
        CFG_GAIN:            gain_r            <= cfg_wdata[AMP_W-1:0];
        CFG_START_AMPLITUDE: start_amplitude_r <= cfg_wdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  pnf_coef_seq #(.MAX_OCTAVES(MAX_OCTAVES)) u_coef_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .restart         (cfg_we),
    .lacunarity      (lacunarity_r),
    .gain            (gain_r),
    .start_amplitude (start_amplitude_r),
    .freq_tab        (freq_tab),
    .amp_tab         (amp_tab),
    .busy            (seq_busy)
  );

  // octave counts above the lane count act as the lane count
  always_comb begin
    if (LIM_W'(octave_count_r) > LIM_W'(MAX_OCTAVES)) begin
      oct_lim = LIM_W'(MAX_OCTAVES);
    end else begin
      oct_lim = LIM_W'(octave_count_r);
    end
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      lane_on[k] = LIM_W'(k) < oct_lim;
    end
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    pnf_octave_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .x_coord (in_x_coord),
      .y_coord (in_y_coord),
      .freq    (freq_tab[k]),
      .amp     (amp_tab[k]),
      .lane_on (lane_on[k]),
      .term    (terms[k])
    );
  end

  pnf_sum #(.MAX_OCTAVES(MAX_OCTAVES), .SUM_W(SUM_W)) u_sum (
    .clk   (clk),
    .en    (adv),
    .terms (terms),
    .sum   (sum)
  );

  // floor to q3.14, then clamp
  always_comb begin
    q = sum >>> OUT_SHIFT;
    if (q > $signed(SUM_W'(OUT_MAX))) begin
      out_noise_sum_nxt = OUT_W'(OUT_MAX);
    end else if (q < $signed(SUM_W'(OUT_MIN))) begin
      out_noise_sum_nxt = OUT_W'(OUT_MIN);
    end else begin
      out_noise_sum_nxt = q[OUT_W-1:0];
    end
  end

  // valid bits travel alongside the lane data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      sum_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LANE_LAT-2:0], in_xfer};
      sum_vld_r   <= vld_r[LANE_LAT-1];
      out_valid_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_noise_sum_r <= out_noise_sum_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_noise_sum = out_noise_sum_r;

  // a held pipe keeps every in-flight item
  a_hold_keeps_items: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(sum_vld_r))
    else $error("pipeline valid bits changed during a stall");

  // a new result only comes from the sum stage
  a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(sum_vld_r))
    else $error("result appeared without a summed item");

  // no coordinate transfer while the tables are rebuilt
  a_no_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_busy |-> !in_xfer)
    else $error("coordinate taken while coefficient tables were stale");

endmodule

>>> tb/tb_perlin_noise_fbm_2d_unit.sv
// tb_perlin_noise_fbm_2d_unit: self-checking bench for the fractal perlin noise unit
// depends on pnf_pkg and perlin_noise_fbm_2d_unit; predicts every sample in fixed point
module tb_perlin_noise_fbm_2d_unit;
  import pnf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int OCT_CAP     = 8;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_x_coord = '0;
  logic signed [COORD_W-1:0] in_y_coord = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [OUT_W-1:0]   out_noise_sum;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DAT_W-1:0]      cfg_wdata = '0;

  // shadow copy of the config registers
  logic [OCT_W-1:0] octaves_q   = RST_OCTAVE_COUNT;
  logic [LAC_W-1:0] lacunarity_q = RST_LACUNARITY;
  logic [AMP_W-1:0] gain_q       = RST_GAIN;
  logic [AMP_W-1:0] amp0_q       = RST_START_AMPLITUDE;

  coord_t                  coord_queue[$];
  logic signed [OUT_W-1:0] sum_queue[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_len   = 0;
  int cycles         = 0;
  int mismatches     = 0;
  int checked        = 0;
  int sent           = 0;

  perlin_noise_fbm_2d_unit dut (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint smooth_step(longint t);
    longint t2, t3, poly;
    t2   = (t * t) >>> FRAC_BITS;
    t3   = (t2 * t) >>> FRAC_BITS;
    poly = 10 * 65536 - ((t * (15 * 65536 - 6 * t)) >>> FRAC_BITS);
    return (t3 * poly) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> FRAC_BITS);
  endfunction

  // dot product with one of the four diagonal gradients
  function automatic longint corner_dot(logic [7:0] h, longint px, longint py);
    longint u, v;
    u = h[1] ? py : px;
    v = h[1] ? px : py;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // one gradient noise sample at a Q.32 point
  function automatic longint lattice_noise(longint sx, longint sy);
    logic [7:0] xi, yi, pa, pb, haa, hab, hba, hbb;
    longint xf, yf, u, v, lo, hi;
    xi  = 8'((sx >>> 32) & 255);
    yi  = 8'((sy >>> 32) & 255);
    xf  = (sx >>> 16) & 65535;
    yf  = (sy >>> 16) & 65535;
    u   = smooth_step(xf);
    v   = smooth_step(yf);
    pa  = PERM_ROM[xi];
    pb  = PERM_ROM[8'(xi + 8'd1)];
    haa = PERM_ROM[8'(pa + yi)];
    hab = PERM_ROM[8'(pa + yi + 8'd1)];
    hba = PERM_ROM[8'(pb + yi)];
    hbb = PERM_ROM[8'(pb + yi + 8'd1)];
    lo  = blend(corner_dot(haa, xf, yf), corner_dot(hba, xf - 65536, yf), u);
    hi  = blend(corner_dot(hab, xf, yf - 65536),
                corner_dot(hbb, xf - 65536, yf - 65536), u);
    return blend(lo, hi, v);
  endfunction

  // octave sum with the current shadow config, saturated to Q3.14
  function automatic logic signed [OUT_W-1:0] fbm_sample(coord_t c);
    longint freq, amp, acc, q, xs, ys;
    int n;
    freq = 65536;
    amp  = amp0_q;
    acc  = 0;
    xs   = c.x;
    ys   = c.y;
    n    = (octaves_q > OCT_CAP) ? OCT_CAP : int'(octaves_q);
    for (int k = 0; k < n; k++) begin
      acc += (amp * lattice_noise(xs * freq, ys * freq)) >>> 16;
      freq = (freq * lacunarity_q) >>> 16;
      if (freq > 64'h7fff_ffff) freq = 64'h7fff_ffff;
      amp = (amp * gain_q) >>> 16;
    end
    q = acc >>> 2;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return OUT_W'(q);
  endfunction

  // ------------------------------------------------------------------ driver

  // a coordinate transfer happens when valid is high and stall low
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        sum_queue.push_back(fbm_sample('{x: in_x_coord, y: in_y_coord}));
        sent++;
      end
      if (coord_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        coord_t c;
        c = coord_queue.pop_front();
        in_valid   <= 1'b1;
        in_x_coord <= c.x;
        in_y_coord <= c.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: a long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_off_len > 0) begin
      out_stall    <= 1'b1;
      hold_off_len <= hold_off_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sum_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: noise_sum %0d", out_noise_sum);
      end else begin
        logic signed [OUT_W-1:0] want;
        want = sum_queue.pop_front();
        checked++;
        if (out_noise_sum !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_sum mismatch: expected %0d actual %0d", want, out_noise_sum);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus

  task automatic wait_drained();
    while (coord_queue.size() > 0 || in_valid || sum_queue.size() > 0)
      @(posedge clk);
    // items cannot be silent, but let the pipeline settle fully
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_OCTAVE_COUNT: octaves_q    = val[OCT_W-1:0];
      CFG_LACUNARITY:   lacunarity_q = val[LAC_W-1:0];
      CFG_GAIN:         gain_q       = val[AMP_W-1:0];
      default:          amp0_q       = val[AMP_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_coord(logic [31:0] x, logic [31:0] y);
    coord_queue.push_back('{x: x, y: y});
  endtask

  // equal shares of full range, near-origin, cell-edge and mid-range coordinates
  task automatic add_random(int count);
    logic [31:0] x, y;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin x = $urandom; y = $urandom; end
        1: begin
          x = 32'($signed($urandom_range(2097151)) - 1048576);
          y = 32'($signed($urandom_range(2097151)) - 1048576);
        end
        2: begin
          // just around a lattice boundary, including the 255 to 0 wrap
          x = {16'($urandom_range(65535) | 32'h00ff), 16'(32'($urandom_range(7)) - 4)};
          y = {16'($urandom), 16'(16'hffff - $urandom_range(7))};
        end
        default: begin x = $urandom & 32'h00ff_ffff; y = -($urandom & 32'h00ff_ffff); end
      endcase
      add_coord(x, y);
    end
  endtask

  // config settings: octaves, lacunarity, gain, start amplitude
  logic [17:0] settings [9][4] = '{
    '{18'd1,  18'd65536,  18'd65535, 18'd65535},
    '{18'd8,  18'd196608, 18'd1,     18'd1},
    '{18'd0,  18'd137626, 18'd31457, 18'd32768},
    '{18'd15, 18'd262143, 18'd65535, 18'd65535},
    '{18'd8,  18'd0,      18'd0,     18'd65535},
    '{18'd5,  18'd196608, 18'd65535, 18'd0},
    '{18'd9,  18'd100000, 18'd40000, 18'd50000},
    '{18'd4,  18'd131072, 18'd32768, 18'd65535},
    '{18'd3,  18'd137626, 18'd31457, 18'd32768}
  };

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, the origin, cell edges and the corner wrap
    add_coord(32'h0000_0000, 32'h0000_0000);
    add_coord(32'h7fff_ffff, 32'h7fff_ffff);
    add_coord(32'h8000_0000, 32'h8000_0000);
    add_coord(32'h7fff_ffff, 32'h8000_0000);
    add_coord(32'hffff_ffff, 32'h0000_0001);
    add_coord(32'h00ff_ffff, 32'h00ff_0000);
    add_coord(32'h0100_0000, 32'hff00_0000);
    add_coord(32'h0000_8000, 32'h0000_8000);
    add_coord(32'h0001_0000, 32'hffff_0000);
    add_coord(32'h5555_5555, 32'haaaa_aaaa);
    add_coord(32'haaaa_aaaa, 32'h5555_5555);
    add_coord(32'h00ff_8000, 32'h00ff_8000);
    wait_drained();

    // max octaves with the largest lacunarity gives the highest octave frequencies
    write_reg(CFG_OCTAVE_COUNT, 18'd8);
    write_reg(CFG_LACUNARITY, 18'd262143);
    add_coord(32'h7fff_ffff, 32'h0000_0001);
    add_coord(32'h1234_5678, 32'hedcb_a987);
    add_coord(32'h8000_0000, 32'h7fff_ffff);
    wait_drained();

    foreach (settings[s]) begin
      write_reg(CFG_OCTAVE_COUNT, settings[s][0]);
      write_reg(CFG_LACUNARITY, settings[s][1]);
      write_reg(CFG_GAIN, settings[s][2]);
      write_reg(CFG_START_AMPLITUDE, settings[s][3]);
      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      add_random(160);
      if (s == 0 || s == 4) begin
        // long receiver hold-off while the sender keeps offering
        hold_off_len <= 300;
        add_random(60);
      end
      // sender pauses until everything has come back
      while (coord_queue.size() > 0 || in_valid || sum_queue.size() > 0)
        @(posedge clk);
      add_random(40);
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    $display("covered %0d coordinate transfers and %0d checked results", sent, checked);
    $display("over %0d config settings, with idle, stall and hold-off phases",
             $size(settings) + 2);
    if (mismatches == 0 && sum_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pnf_pkg.sv
hw/rtl/pnf_coef_seq.sv
hw/rtl/pnf_octave_lane.sv
hw/rtl/pnf_sum.sv
hw/rtl/perlin_noise_fbm_2d_unit.sv
tb/tb_perlin_noise_fbm_2d_unit.sv
